[design/owm_pkg.sv]
`timescale 1ns / 1ps

package owm_pkg;

  localparam int CntWidth  = 10;
  localparam int BitWidth  = 4;
  localparam int ByteWidth = 8;
  localparam int CfgAddrWidth = 3;
  localparam int CfgDataWidth = 10;
  localparam int InDataWidth  = 16;
  localparam int OutDataWidth = 16;

  localparam logic [CntWidth-1:0] CntMax = 10'd1023;
  localparam logic [BitWidth-1:0] BitsPerByte = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_REL    = 4'd2,
    PH_PRES_WAIT  = 4'd3,
    PH_PRES_END   = 4'd4,
    PH_SLOT_LOW   = 4'd5,
    PH_WR_HOLD    = 4'd6,
    PH_RD_SAMPLE  = 4'd7,
    PH_RD_RECOVER = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    OP_RESET      = 3'd0,
    OP_WRITE_BYTE = 3'd1,
    OP_READ_BYTE  = 3'd2,
    OP_WRITE_BIT  = 3'd3,
    OP_READ_BIT   = 3'd4
  } op_t;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_RELEASE = 3'd1,
    REG_PRESENCE_WAIT = 3'd2,
    REG_PRESENCE_END  = 3'd3,
    REG_SLOT_START    = 3'd4,
    REG_SLOT_HOLD     = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_READ_RECOVER  = 3'd7
  } cfg_reg_t;

  localparam logic [9:0] ResetLowInit     = 10'd750;
  localparam logic [7:0] ResetReleaseInit = 8'd15;
  localparam logic [9:0] PresenceWaitInit = 10'd200;
  localparam logic [9:0] PresenceEndInit  = 10'd240;
  localparam logic [7:0] SlotStartInit    = 8'd2;
  localparam logic [7:0] SlotHoldInit     = 8'd60;
  localparam logic [7:0] ReadSampleInit   = 8'd12;
  localparam logic [7:0] ReadRecoverInit  = 8'd50;

  // first member sits in the highest bits
  typedef struct packed {
    logic                 tick_us;
    logic                 line_level;
    logic [ByteWidth-1:0] tx_byte;
    logic [2:0]           opcode;
    logic                 cmd_valid;
  } cmd_item_t;

  typedef struct packed {
    logic                 presence_fail;
    logic [ByteWidth-1:0] rx_byte;
    logic                 done_res;
    logic                 busy_res;
    logic                 drive_low;
  } result_item_t;

endpackage

[design/one_wire_bus_master_top.sv]
`timescale 1ns / 1ps

// 1-wire bus master, one item per clock: every input transfer carries a command
// slot, the sampled bus level and a microsecond tick strobe, and gives exactly one
// result transfer with the drive level and status after that item. The whole
// update is combinational between the state registers and a result register, so
// a new item is taken every cycle while the result register is empty or being
// taken (s_tready = !m_tvalid || m_tready). Bus timing is counted in ticks against
// the configuration registers, which take effect as soon as they are written.
module one_wire_bus_master_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // cmd_valid, opcode[2:0], tx_byte[7:0], line_level, tick_us, unused pad
  input  logic [owm_pkg::InDataWidth-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // drive_low, busy_res, done_res, rx_byte[7:0], presence_fail, zero pad
  output logic [owm_pkg::OutDataWidth-1:0]     m_tdata,
  input  logic                                 cfg_we,
  input  logic [owm_pkg::CfgAddrWidth-1:0]     cfg_addr,
  input  logic [owm_pkg::CfgDataWidth-1:0]     cfg_data
);
  import owm_pkg::*;

  logic [9:0] reset_low_us;
  logic [7:0] reset_release_us;
  logic [9:0] presence_wait_max;
  logic [9:0] presence_end_max;
  logic [7:0] slot_start_us;
  logic [7:0] slot_hold_us;
  logic [7:0] read_sample_us;
  logic [7:0] read_recover_us;

  phase_t               phase, phase_next;
  logic [2:0]           current_op, current_op_next;
  logic [CntWidth-1:0]  us_counter, us_counter_next;
  logic [BitWidth-1:0]  bit_count, bit_count_next;
  logic [ByteWidth-1:0] shift_reg, shift_reg_next;
  logic                 drive_state, drive_state_next;

  result_item_t out_q;
  result_item_t res;
  cmd_item_t    cmd;
  logic         accept;

  logic [CntWidth-1:0]  cnt_tick;
  logic [CntWidth-1:0]  limit;
  logic                 timer_hit;
  logic                 seen;
  logic [BitWidth-1:0]  bit_inc;
  logic                 last_bit;
  logic                 is_read;

  assign cmd      = cmd_item_t'(s_tdata[$bits(cmd_item_t)-1:0]);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_us      <= ResetLowInit;
      reset_release_us  <= ResetReleaseInit;
      presence_wait_max <= PresenceWaitInit;
      presence_end_max  <= PresenceEndInit;
      slot_start_us     <= SlotStartInit;
      slot_hold_us      <= SlotHoldInit;
      read_sample_us    <= ReadSampleInit;
      read_recover_us   <= ReadRecoverInit;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_RESET_LOW:     reset_low_us      <= cfg_data;
        REG_RESET_RELEASE: reset_release_us  <= cfg_data[7:0];
        REG_PRESENCE_WAIT: presence_wait_max <= cfg_data;
        REG_PRESENCE_END:  presence_end_max  <= cfg_data;
        REG_SLOT_START:    slot_start_us     <= cfg_data[7:0];
        REG_SLOT_HOLD:     slot_hold_us      <= cfg_data[7:0];
        REG_READ_SAMPLE:   read_sample_us    <= cfg_data[7:0];
        REG_READ_RECOVER:  read_recover_us   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // saturating tick count and the one limit compare shared by all timed phases
  assign cnt_tick = (cmd.tick_us && us_counter < CntMax) ? us_counter + 1'b1 : us_counter;

  always_comb begin
    case (phase)
      PH_RST_LOW:    limit = reset_low_us;
      PH_RST_REL:    limit = {2'b00, reset_release_us};
      PH_PRES_WAIT:  limit = presence_wait_max;
      PH_PRES_END:   limit = presence_end_max;
      PH_SLOT_LOW:   limit = {2'b00, slot_start_us};
      PH_WR_HOLD:    limit = {2'b00, slot_hold_us};
      PH_RD_SAMPLE:  limit = {2'b00, read_sample_us};
      PH_RD_RECOVER: limit = {2'b00, read_recover_us};
      default:       limit = '0;
    endcase
  end

  assign timer_hit = cnt_tick >= limit;
  assign seen      = (phase == PH_PRES_WAIT) ? !cmd.line_level : cmd.line_level;
  assign bit_inc   = bit_count + 1'b1;
  assign last_bit  = current_op == OP_WRITE_BIT || current_op == OP_READ_BIT ||
                     bit_inc >= BitsPerByte;
  assign is_read   = current_op == OP_READ_BYTE || current_op == OP_READ_BIT;

  always_comb begin
    phase_next       = phase;
    current_op_next  = current_op;
    us_counter_next  = us_counter;
    bit_count_next   = bit_count;
    shift_reg_next   = shift_reg;
    drive_state_next = drive_state;
    res              = '0;

    case (phase)
      PH_IDLE: begin
        if (cmd.cmd_valid && cmd.opcode <= OP_READ_BIT) begin
          current_op_next  = cmd.opcode;
          bit_count_next   = '0;
          us_counter_next  = '0;
          drive_state_next = 1'b1;
          if (cmd.opcode == OP_RESET) begin
            shift_reg_next = '0;
            phase_next     = PH_RST_LOW;
          end else begin
            shift_reg_next = (cmd.opcode == OP_WRITE_BYTE || cmd.opcode == OP_WRITE_BIT) ?
                             cmd.tx_byte : '0;
            phase_next     = PH_SLOT_LOW;
          end
        end
      end
      PH_RST_LOW, PH_RST_REL: begin
        us_counter_next = cnt_tick;
        if (timer_hit) begin
          phase_next       = (phase == PH_RST_LOW) ? PH_RST_REL : PH_PRES_WAIT;
          us_counter_next  = '0;
          drive_state_next = 1'b0;
        end
      end
      PH_PRES_WAIT, PH_PRES_END: begin
        // the line is checked against the count before this item's tick
        if (seen && us_counter < limit) begin
          us_counter_next  = '0;
          drive_state_next = 1'b0;
          if (phase == PH_PRES_WAIT) begin
            phase_next = PH_PRES_END;
          end else begin
            phase_next   = PH_IDLE;
            res.done_res = 1'b1;
          end
        end else begin
          us_counter_next = cnt_tick;
          if (timer_hit) begin
            phase_next        = PH_IDLE;
            us_counter_next   = '0;
            drive_state_next  = 1'b0;
            res.done_res      = 1'b1;
            res.presence_fail = 1'b1;
          end
        end
      end
      PH_SLOT_LOW: begin
        us_counter_next = cnt_tick;
        if (timer_hit) begin
          us_counter_next = '0;
          if (is_read) begin
            phase_next       = PH_RD_SAMPLE;
            drive_state_next = 1'b0;
          end else begin
            phase_next       = PH_WR_HOLD;
            drive_state_next = !shift_reg[0];
          end
        end
      end
      PH_RD_SAMPLE: begin
        us_counter_next = cnt_tick;
        if (timer_hit) begin
          shift_reg_next   = {cmd.line_level, shift_reg[ByteWidth-1:1]};
          phase_next       = PH_RD_RECOVER;
          us_counter_next  = '0;
          drive_state_next = 1'b0;
        end
      end
      PH_WR_HOLD, PH_RD_RECOVER: begin
        us_counter_next = cnt_tick;
        if (timer_hit) begin
          if (phase == PH_WR_HOLD) begin
            shift_reg_next = {1'b0, shift_reg[ByteWidth-1:1]};
          end
          bit_count_next  = bit_inc;
          us_counter_next = '0;
          if (last_bit) begin
            phase_next       = PH_IDLE;
            drive_state_next = 1'b0;
            res.done_res     = 1'b1;
            if (phase == PH_RD_RECOVER) begin
              res.rx_byte = (current_op == OP_READ_BIT) ?
                            {{(ByteWidth-1){1'b0}}, shift_reg[ByteWidth-1]} : shift_reg;
            end
          end else begin
            // next slot opens in the very next item
            phase_next       = PH_SLOT_LOW;
            drive_state_next = 1'b1;
          end
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        us_counter_next  = '0;
        drive_state_next = 1'b0;
      end
    endcase

    res.drive_low = drive_state_next;
    res.busy_res  = phase_next != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      current_op  <= '0;
      us_counter  <= '0;
      bit_count   <= '0;
      shift_reg   <= '0;
      drive_state <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      current_op  <= current_op_next;
      us_counter  <= us_counter_next;
      bit_count   <= bit_count_next;
      shift_reg   <= shift_reg_next;
      drive_state <= drive_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign m_tdata = {{(OutDataWidth-$bits(result_item_t)){1'b0}}, out_q};

  // a completing command always leaves the block idle
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_q.done_res |-> !out_q.busy_res)
    else $error("done result still marked busy");

  // presence failure is only reported with a done
  a_fail_with_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_q.presence_fail |-> out_q.done_res)
    else $error("presence_fail without done");

  // the bus is released whenever nothing is in progress
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> !drive_state)
    else $error("bus driven low while idle");

  // a byte never runs past eight slots
  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BitsPerByte)
    else $error("bit count beyond a byte");

  // state only moves on a transfer
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase) && $stable(us_counter) && $stable(shift_reg))
    else $error("state changed without an input transfer");

endmodule
